/* src/smf_pkg.sv */
// Shared types and defaults for the sliding-window median filter.
// No dependencies; used by smf_cell and sliding_median_filter.
package smf_pkg;

  localparam int unsigned DefaultWindow     = 8;
  localparam int unsigned DefaultSampleBits = 12;

  // Control handed between neighboring cells.
  typedef struct packed {
    logic gt;        // cell value is greater than the incoming sample
    logic del_thru;  // the oldest entry sits in this cell or to its left
  } smf_ctrl_t;

endpackage

/* src/smf_cell.sv */
// One cell of the sorted window: a sample value and its age.
// Depends on smf_pkg for the neighbor control struct.
module smf_cell
  import smf_pkg::*;
#(
  parameter int unsigned WINDOW      = DefaultWindow,
  parameter int unsigned SAMPLE_BITS = DefaultSampleBits,
  parameter int unsigned RESET_AGE   = 0,
  localparam int unsigned AW         = $clog2(WINDOW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] left_val_i,
  input  logic [AW-1:0]          left_age_i,
  input  smf_ctrl_t              left_ctrl_i,
  input  logic [SAMPLE_BITS-1:0] right_val_i,
  input  logic [AW-1:0]          right_age_i,
  input  smf_ctrl_t              right_ctrl_i,
  output logic [SAMPLE_BITS-1:0] val_o,
  output logic [AW-1:0]          age_o,
  output smf_ctrl_t              ctrl_o,
  output logic [SAMPLE_BITS-1:0] val_d_o
);

  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AW-1:0]          age_q, age_d;
  logic                   oldest;

  assign oldest          = (age_q == AW'(WINDOW - 1));
  assign ctrl_o.gt       = (val_q > sample_i);
  assign ctrl_o.del_thru = left_ctrl_i.del_thru | oldest;

  // Oldest entry removed, sample inserted; data moves at most one cell.
  always_comb begin
    val_d = val_q;
    age_d = age_q + AW'(1);
    if (!left_ctrl_i.del_thru && !oldest) begin
      // removal happens to the right
      if (ctrl_o.gt) begin
        if (left_ctrl_i.gt) begin
          val_d = left_val_i;
          age_d = left_age_i + AW'(1);
        end else begin
          val_d = sample_i;
          age_d = '0;
        end
      end
    end else begin
      // removal here or to the left: the row closes up from the right
      if (!right_ctrl_i.gt) begin
        val_d = right_val_i;
        age_d = right_age_i + AW'(1);
      end else if (oldest ? !left_ctrl_i.gt : !ctrl_o.gt) begin
        val_d = sample_i;
        age_d = '0;
      end else if (oldest) begin
        val_d = left_val_i;
        age_d = left_age_i + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= AW'(RESET_AGE);
    end else if (en_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o   = val_q;
  assign age_o   = age_q;
  assign val_d_o = val_d;

endmodule

/* src/sliding_median_filter.sv */
// Top level of the sliding-window median filter: a sorted row of cells.
// Depends on smf_pkg and smf_cell.
//
// Sliding-window median filter. Each accepted sample replaces the oldest of the
// last WINDOW samples and the block answers with element WINDOW>>1 of the window
// in ascending order (the true median for odd WINDOW, the upper middle value for
// even WINDOW). The window is kept permanently sorted in a row of WINDOW cells,
// each holding one sample and its age; on a transaction the oldest entry drops
// out and the new sample slides into place, every cell taking its own value or a
// neighbor's. The window starts as all zeros, so the first WINDOW-1 results
// count those zeros. Throughput is one sample per clock while the receiver
// keeps up; the result is written to an output register as the sample is
// taken. The next sample is accepted in the same cycle the waiting result is
// taken; while a result sits unread, the input stalls. The critical path is the
// compare against the new sample plus the ripple of the
// "oldest entry seen" flag along the cell row, which grows linearly with WINDOW.
module sliding_median_filter
  import smf_pkg::*;
#(
  parameter int unsigned WINDOW      = DefaultWindow,
  parameter int unsigned SAMPLE_BITS = DefaultSampleBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] median_value_o
);

  localparam int unsigned AW  = $clog2(WINDOW);
  localparam int unsigned MID = WINDOW >> 1;

  logic                   accept;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] median_q;

  logic [SAMPLE_BITS-1:0] val   [WINDOW];
  logic [SAMPLE_BITS-1:0] val_d [WINDOW];
  logic [AW-1:0]          age   [WINDOW];
  smf_ctrl_t              ctrl  [WINDOW];

  // Output register frees the input side whenever it is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lv, rv;
    logic [AW-1:0]          la, ra;
    smf_ctrl_t              lc, rc;

    // Row ends: minus infinity on the left, plus infinity on the right.
    if (i == 0) begin : g_left_end
      assign lv = '0;
      assign la = '0;
      assign lc = '{gt: 1'b0, del_thru: 1'b0};
    end else begin : g_left
      assign lv = val[i-1];
      assign la = age[i-1];
      assign lc = ctrl[i-1];
    end
    if (i == WINDOW - 1) begin : g_right_end
      assign rv = '0;
      assign ra = '0;
      assign rc = '{gt: 1'b1, del_thru: 1'b1};
    end else begin : g_right
      assign rv = val[i+1];
      assign ra = age[i+1];
      assign rc = ctrl[i+1];
    end

    smf_cell #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .RESET_AGE   (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (accept),
      .sample_i     (sample_i),
      .left_val_i   (lv),
      .left_age_i   (la),
      .left_ctrl_i  (lc),
      .right_val_i  (rv),
      .right_age_i  (ra),
      .right_ctrl_i (rc),
      .val_o        (val[i]),
      .age_o        (age[i]),
      .ctrl_o       (ctrl[i]),
      .val_d_o      (val_d[i])
    );
  end

  // Median is the middle cell after this transaction's update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      median_q <= val_d[MID];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_value_o = median_q;

  // Checks on the cell row.
  logic [WINDOW-1:0] oldest_vec;
  logic [WINDOW-1:0] sorted_ok;

  for (genvar k = 0; k < WINDOW; k++) begin : g_chk
    assign oldest_vec[k] = (age[k] == AW'(WINDOW - 1));
    if (k == 0) begin : g_first
      assign sorted_ok[k] = 1'b1;
    end else begin : g_rest
      assign sorted_ok[k] = (val[k-1] <= val[k]);
    end
  end

  a_one_oldest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(oldest_vec))
    else $error("cell row must hold exactly one oldest entry");

  a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    &sorted_ok)
    else $error("cell row lost ascending order");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q)
    else $error("input stalled with empty output register");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted sample produced no result");

endmodule

/* bench/tb_sliding_median_filter.sv */
// Self-checking testbench for sliding_median_filter: directed table, then random sample streams.
// Depends on smf_pkg and sliding_median_filter; predicts each median unless the table gives it.
module tb_sliding_median_filter
  import smf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN   = DefaultWindow;
  localparam int unsigned SBITS = DefaultSampleBits;
  localparam int unsigned MAXV  = (1 << SBITS) - 1;

  // Run shape: random item count, where the sender drains the pipe, when the
  // receiver starts its long hold-off and how long that lasts.
  localparam int RAND_ITEMS  = 1130;
  localparam int PAUSE_AT    = 700;
  localparam int HOLD_AT     = 300;
  localparam int LONG_HOLD   = 60;
  // No transaction on either channel for this many cycles means a hang.
  // Worst correct case is the long hold-off plus a sender gap, well below this.
  localparam int STUCK_LIMIT = 2000;

  typedef logic [SBITS-1:0] sample_t;

  // Directed row: sample to send, and an expected median where it is obvious.
  typedef struct packed {
    logic    known;
    sample_t value;
    sample_t result;
  } dir_row_t;

  // Shapes of random sample streams.
  typedef enum int {
    SH_UNIFORM,
    SH_EXTREME,
    SH_CLUSTER,
    SH_RAMP,
    SH_IMPULSE
  } shape_e;

  // Directed part. The window starts as zeros:
  //   three full-scale samples still leave five zeros, so the median stays 0;
  //   the fourth makes four of each, and the upper middle is full scale;
  //   zeros into slots that already hold zero change nothing;
  //   the ninth sample wraps and overwrites the oldest full-scale entry.
  // Then bit patterns, neighbors of the extremes, ties and single spikes.
  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b1, 12'hFFF, 12'h000},
    '{1'b1, 12'hFFF, 12'h000},
    '{1'b1, 12'hFFF, 12'h000},
    '{1'b1, 12'hFFF, 12'hFFF},
    '{1'b1, 12'h000, 12'hFFF},
    '{1'b1, 12'h000, 12'hFFF},
    '{1'b1, 12'h000, 12'hFFF},
    '{1'b1, 12'h000, 12'hFFF},
    '{1'b1, 12'h000, 12'h000},
    '{1'b0, 12'hAAA, 12'h000},
    '{1'b0, 12'h555, 12'h000},
    '{1'b0, 12'h001, 12'h000},
    '{1'b0, 12'h800, 12'h000},
    '{1'b0, 12'h7FF, 12'h000},
    '{1'b0, 12'hFFE, 12'h000},
    '{1'b0, 12'h123, 12'h000},
    '{1'b0, 12'h123, 12'h000},
    '{1'b0, 12'h123, 12'h000},
    '{1'b0, 12'h123, 12'h000},
    '{1'b0, 12'h000, 12'h000},
    '{1'b0, 12'hFFF, 12'h000},
    '{1'b0, 12'h456, 12'h000},
    '{1'b0, 12'h456, 12'h000},
    '{1'b0, 12'h456, 12'h000}
  };

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  sample_t sample_i    = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  sample_t median_value_o;

  // Side data that travels with each input transaction.
  logic    row_known  = 1'b0;
  sample_t row_result = '0;

  // Predictor state: our own copy of the window and its write slot.
  sample_t win_hist [WIN];
  int      wr_idx = 0;

  // Medians still owed by the block, oldest first.
  sample_t median_q [$];

  int mismatches   = 0;
  int results_seen = 0;
  int stuck_cycles = 0;

  // Sender burst bookkeeping.
  int burst_left = 0;
  bit no_gaps    = 1'b0;

  // Receiver stall bookkeeping.
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;
  int  stall_style = 0;
  int  style_left  = 0;
  int  rx_cyc      = 0;
  logic rx_holding;
  assign rx_holding = (hold_left != 0);

  // Random stream state.
  shape_e  shape      = SH_UNIFORM;
  int      shape_left = 0;
  sample_t level      = '0;
  bit      ramp_up    = 1'b1;

  sliding_median_filter #(
    .WINDOW      (WIN),
    .SAMPLE_BITS (SBITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .median_value_o (median_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int k = 0; k < WIN; k++) begin
      win_hist[k] = '0;
    end
  end

  // Write the sample over the oldest slot, then sort a copy and take the
  // element at WIN>>1 (upper middle for an even window).
  function automatic sample_t predict_median(input sample_t s);
    sample_t srt [WIN];
    sample_t key;
    int j;
    win_hist[wr_idx] = s;
    wr_idx = (wr_idx == WIN - 1) ? 0 : wr_idx + 1;
    for (int k = 0; k < WIN; k++) begin
      srt[k] = win_hist[k];
    end
    for (int k = 1; k < WIN; k++) begin
      key = srt[k];
      j = k;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    return srt[WIN >> 1];
  endfunction

  // Random samples come in segments of one shape: uniform noise, rail values,
  // tight clusters (lots of ties), slow ramps, and a flat level with spikes.
  function automatic sample_t draw_sample();
    sample_t s;
    if (shape_left == 0) begin
      shape      = shape_e'($urandom_range(0, 4));
      shape_left = $urandom_range(16, 80);
      level      = sample_t'($urandom_range(0, MAXV));
      ramp_up    = ($urandom_range(0, 1) == 1);
    end
    shape_left--;
    case (shape)
      SH_UNIFORM: s = sample_t'($urandom_range(0, MAXV));
      SH_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       s = '0;
          1:       s = '1;
          2:       s = sample_t'(1);
          default: s = sample_t'(MAXV - 1);
        endcase
      end
      SH_CLUSTER: s = level + sample_t'($urandom_range(0, 3));
      SH_RAMP: begin
        level = ramp_up ? level + sample_t'(37) : level - sample_t'(37);
        s = level;
      end
      default: begin
        if ($urandom_range(0, 9) == 0) begin
          s = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          s = level + sample_t'($urandom_range(0, 7));
        end
      end
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
    if (mismatches < 20) begin
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Offer one sample; a gap of random length may come first when a burst ends.
  // Returns at the edge where the transaction is taken.
  task automatic offer_sample(input sample_t s, input bit known, input sample_t res);
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      // Keep offering while the receiver is in its long hold-off, so the
      // block fills up and has to stall its input.
      if (!rx_holding && !no_gaps) begin
        gap = $urandom_range(0, 12);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    row_known  <= known;
    row_result <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every owed median has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (median_q.size() != 0);
  endtask

  // Receiver: a one-time long hold-off once enough results have come, and
  // otherwise a rotating stall style: always ready, coin flip, ready three
  // quarters of the time, or ready only a fifth of the time.
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left   <= LONG_HOLD;
      hold_done   <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        style_left  <= $urandom_range(10, 60);
      end else begin
        style_left  <= style_left - 1;
      end
      case (stall_style)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 1) == 1);
        2:       out_ready_i <= (rx_cyc % 4 != 3);
        default: out_ready_i <= (rx_cyc % 5 == 0);
      endcase
    end
  end

  // Scoreboard: on each input transaction predict the median and queue it;
  // on each output transaction compare with the oldest queued median. The
  // push comes first so a same-edge result would still find its entry.
  always @(posedge clk_i) begin : median_check
    sample_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = predict_median(sample_i);
        if (row_known) begin
          want = row_result;
        end
        median_q.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (median_q.size() == 0) begin
          report_mismatch("result with nothing pending", median_value_o, '0);
        end else begin
          want = median_q.pop_front();
          if (median_value_o !== want) begin
            report_mismatch("median_value", median_value_o, want);
          end
        end
      end
    end
  end

  // Hang detector: any transaction on either side resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < DIR_ROWS; n++) begin
      offer_sample(DIR_TAB[n].value, DIR_TAB[n].known, DIR_TAB[n].result);
    end

    // First stretch of the random part runs back to back on the send side.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      no_gaps = (n < 100);
      if (n == PAUSE_AT) begin
        drain_results();
      end
      offer_sample(draw_sample(), 1'b0, '0);
    end

    drain_results();
    // The extra wait below catches any stray result.
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
